// ----- design/ymrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ymrc_pkg
// Shared types and constants of the YMODEM receive controller: byte codes,
// result kinds, process codes, register indexes and the result bundle.
// ----------------------------------------------------------------------------
package ymrc_pkg;

  localparam int MAX_FRAME_DEFAULT = 2047;
  localparam int MAX_RESULTS       = 3;

  localparam int ADDR_W    = 32;
  localparam int HALF_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int ERASE_W   = 4;
  localparam int TICK_W    = 16;
  localparam int PAYLOAD_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_SOH = 11'd128;
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_STX = 11'd1024;
  localparam int                   HEADER_LEN  = 3;

  localparam logic [BYTE_W-1:0] BYTE_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] BYTE_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] BYTE_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] BYTE_C   = 8'h43;
  localparam logic [BYTE_W-1:0] BYTE_UPD = 8'h31;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  localparam logic [1:0] KIND_PROGRAM = 2'd0;
  localparam logic [1:0] KIND_ERASE   = 2'd1;
  localparam logic [1:0] KIND_TX      = 2'd2;

  localparam logic [1:0] PROC_START   = 2'd0;
  localparam logic [1:0] PROC_BUSY    = 2'd1;
  localparam logic [1:0] PROC_UPDATE  = 2'd2;
  localparam logic [1:0] PROC_SUCCESS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DOWNLOAD_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS    = 2'd2;

  localparam logic [ADDR_W-1:0]  RESET_DOWNLOAD_BASE = 32'd0;
  localparam logic [ERASE_W-1:0] RESET_ERASE_COUNT   = 4'd1;
  localparam logic [TICK_W-1:0]  RESET_IDLE_TICKS    = 16'd1000;

  typedef enum logic [3:0] {
    ST_START = 4'b0001,
    ST_DATA  = 4'b0010,
    ST_EOT2  = 4'b0100,
    ST_CLOSE = 4'b1000
  } proto_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  download_base;
    logic [ERASE_W-1:0] erase_count;
    logic [TICK_W-1:0]  idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] flash_address;
    logic [HALF_W-1:0] halfword;
    logic [BYTE_W-1:0] tx_byte;
  } result_t;

  typedef struct packed {
    logic [1:0]                   count;
    logic [1:0]                   process;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

endpackage : ymrc_pkg
`default_nettype wire

// ----- design/ymodem_receive_controller_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ymodem_receive_controller_unit
// YMODEM receive controller: frames UART bytes by idle gap and runs the
// receive sequence, producing flash program, erase and transmit results.
// ----------------------------------------------------------------------------
// Each input (a byte or a tick) is registered, decided combinationally and
// causes zero to three results, which leave one per cycle from the result
// register unless the receiver stalls. An input is taken every cycle as long
// as results drain: an input with k results occupies the output until all k
// have left, so the input side waits only when an input with results arrives
// while an earlier bundle of several results is still leaving, or while the
// receiver stalls a held result. Inputs with no results never wait.
// Configuration writes take effect at the next clock edge.
module ymodem_receive_controller_unit #(
  parameter int MAX_FRAME = ymrc_pkg::MAX_FRAME_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_enable,
  input  wire logic [ymrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ymrc_pkg::ADDR_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           action,
  input  wire logic [ymrc_pkg::BYTE_W-1:0]    rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          kind,
  output logic [ymrc_pkg::ADDR_W-1:0]         flash_address,
  output logic [ymrc_pkg::HALF_W-1:0]         halfword,
  output logic [ymrc_pkg::BYTE_W-1:0]         tx_byte,
  output logic [1:0]                          process,
  output logic                                last
);
  import ymrc_pkg::*;

  cfg_t              cfg;
  bundle_t           bundle;
  logic              in_full;
  logic              in_action;
  logic [BYTE_W-1:0] in_byte;
  logic              q_ready;
  logic              fire;
  logic              accept;

  assign fire     = in_full && (q_ready || bundle.count == 2'd0);
  assign in_stall = in_full && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_action <= action;
      in_byte   <= rx_byte;
    end
  end

  ymrc_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  ymrc_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .action  (in_action),
    .rx_byte (in_byte),
    .bundle  (bundle)
  );

  ymrc_out_queue u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (fire && bundle.count != 2'd0),
    .push_bundle   (bundle),
    .ready         (q_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .flash_address (flash_address),
    .halfword      (halfword),
    .tx_byte       (tx_byte),
    .process       (process),
    .last          (last)
  );

endmodule : ymodem_receive_controller_unit
`default_nettype wire

// ----- design/ymrc_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ymrc_cfg
// Configuration registers: download base, erase count and idle tick limit.
// ----------------------------------------------------------------------------
module ymrc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_enable,
  input  wire logic [ymrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ymrc_pkg::ADDR_W-1:0]    cfg_data,
  output ymrc_pkg::cfg_t                      cfg
);
  import ymrc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.download_base <= RESET_DOWNLOAD_BASE;
      regs.erase_count   <= RESET_ERASE_COUNT;
      regs.idle_ticks    <= RESET_IDLE_TICKS;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_DOWNLOAD_BASE: regs.download_base <= cfg_data;
        CFG_ERASE_COUNT:   regs.erase_count   <= cfg_data[ERASE_W-1:0];
        CFG_IDLE_TICKS:    regs.idle_ticks    <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule : ymrc_cfg
`default_nettype wire

// ----- design/ymrc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ymrc_core
// Frame assembly, idle timer and receive sequence. Turns one registered
// byte or tick into a bundle of up to three results and updates its state.
// ----------------------------------------------------------------------------
module ymrc_core #(
  parameter int MAX_FRAME = ymrc_pkg::MAX_FRAME_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ymrc_pkg::cfg_t              cfg,
  input  wire logic                        fire,
  input  wire logic                        action,
  input  wire logic [ymrc_pkg::BYTE_W-1:0] rx_byte,
  output ymrc_pkg::bundle_t                bundle
);
  import ymrc_pkg::*;

  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME);
  localparam logic [LEN_W-1:0] LEN_HDR = LEN_W'(HEADER_LEN);

  proto_state_t      proto_state, proto_state_next;
  logic [1:0]        process_code, process_code_next;
  logic [ADDR_W-1:0] write_address, write_address_next;
  logic [BYTE_W-1:0] frame_type, frame_type_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [TICK_W-1:0] idle_counter, idle_counter_next;
  logic              idle_armed, idle_armed_next;
  logic [BYTE_W-1:0] low_byte, low_byte_next;

  logic                 is_block;
  logic [PAYLOAD_W-1:0] pay_size;
  logic [LEN_W-1:0]     pay_end;
  logic [LEN_W-1:0]     rel;
  logic [LEN_W-1:0]     rel_m1;
  logic [TICK_W-1:0]    cnt_inc;
  logic                 expire;

  assign is_block = (frame_type == BYTE_SOH) || (frame_type == BYTE_STX);
  assign pay_size = (frame_type == BYTE_STX) ? PAYLOAD_STX : PAYLOAD_SOH;
  assign pay_end  = LEN_HDR + LEN_W'(pay_size);
  assign rel      = frame_length - LEN_HDR;
  assign rel_m1   = rel - LEN_W'(1);
  assign cnt_inc  = idle_counter + TICK_W'(1);
  assign expire   = (cnt_inc >= cfg.idle_ticks) || (cnt_inc == '0);

  always_comb begin
    proto_state_next   = proto_state;
    process_code_next  = process_code;
    write_address_next = write_address;
    frame_type_next    = frame_type;
    frame_length_next  = frame_length;
    idle_counter_next  = idle_counter;
    idle_armed_next    = idle_armed;
    low_byte_next      = low_byte;
    bundle             = '0;

    if (action == ACTION_BYTE) begin
      idle_counter_next = '0;
      idle_armed_next   = 1'b1;
      if (frame_length < LEN_MAX) begin
        frame_length_next = frame_length + LEN_W'(1);
        if (frame_length == '0) begin
          frame_type_next = rx_byte;
        end else if (proto_state == ST_DATA && is_block &&
                     frame_length >= LEN_HDR && frame_length < pay_end) begin
          if (!rel[0]) begin
            low_byte_next = rx_byte;
          end else begin
            bundle.count                = 2'd1;
            bundle.res[0].kind          = KIND_PROGRAM;
            bundle.res[0].flash_address = write_address +
                                          {{(ADDR_W-LEN_W){1'b0}}, rel_m1};
            bundle.res[0].halfword      = {rx_byte, low_byte};
          end
        end
      end
    end else if (idle_armed) begin
      idle_counter_next = cnt_inc;
      if (expire) begin
        idle_armed_next   = 1'b0;
        idle_counter_next = '0;
        if (frame_length != '0) begin
          frame_length_next = '0;
          unique case (proto_state)
            ST_START: begin
              if (frame_type == BYTE_SOH) begin
                process_code_next           = PROC_BUSY;
                write_address_next          = cfg.download_base;
                proto_state_next            = ST_DATA;
                bundle.count                = 2'd3;
                bundle.res[0].kind          = KIND_ERASE;
                bundle.res[0].flash_address = cfg.download_base;
                bundle.res[0].halfword      = {{(HALF_W-ERASE_W){1'b0}}, cfg.erase_count};
                bundle.res[1].kind          = KIND_TX;
                bundle.res[1].tx_byte       = BYTE_ACK;
                bundle.res[2].kind          = KIND_TX;
                bundle.res[2].tx_byte       = BYTE_C;
              end else if (frame_type == BYTE_UPD) begin
                process_code_next = PROC_UPDATE;
              end
            end
            ST_DATA: begin
              if (is_block) begin
                write_address_next    = write_address +
                                        {{(ADDR_W-PAYLOAD_W){1'b0}}, pay_size};
                bundle.count          = 2'd1;
                bundle.res[0].kind    = KIND_TX;
                bundle.res[0].tx_byte = BYTE_ACK;
              end else if (frame_type == BYTE_EOT) begin
                proto_state_next      = ST_EOT2;
                bundle.count          = 2'd1;
                bundle.res[0].kind    = KIND_TX;
                bundle.res[0].tx_byte = BYTE_NAK;
              end else begin
                proto_state_next = ST_START;
              end
            end
            ST_EOT2: begin
              if (frame_type == BYTE_EOT) begin
                proto_state_next      = ST_CLOSE;
                bundle.count          = 2'd2;
                bundle.res[0].kind    = KIND_TX;
                bundle.res[0].tx_byte = BYTE_ACK;
                bundle.res[1].kind    = KIND_TX;
                bundle.res[1].tx_byte = BYTE_C;
              end
            end
            ST_CLOSE: begin
              if (frame_type == BYTE_SOH) begin
                proto_state_next      = ST_START;
                process_code_next     = PROC_SUCCESS;
                bundle.count          = 2'd1;
                bundle.res[0].kind    = KIND_TX;
                bundle.res[0].tx_byte = BYTE_ACK;
              end
            end
            default: begin
              proto_state_next = ST_START;
            end
          endcase
        end
      end
    end

    bundle.process = process_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proto_state   <= ST_START;
      process_code  <= PROC_START;
      write_address <= '0;
      frame_type    <= '0;
      frame_length  <= '0;
      idle_counter  <= '0;
      idle_armed    <= 1'b0;
      low_byte      <= '0;
    end else if (fire) begin
      proto_state   <= proto_state_next;
      process_code  <= process_code_next;
      write_address <= write_address_next;
      frame_type    <= frame_type_next;
      frame_length  <= frame_length_next;
      idle_counter  <= idle_counter_next;
      idle_armed    <= idle_armed_next;
      low_byte      <= low_byte_next;
    end
  end

endmodule : ymrc_core
`default_nettype wire

// ----- design/ymrc_out_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ymrc_out_queue
// Result register: holds one bundle and sends its results one per transfer.
// Takes the next bundle in the cycle its last result leaves.
// ----------------------------------------------------------------------------
module ymrc_out_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire ymrc_pkg::bundle_t           push_bundle,
  output logic                             ready,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       kind,
  output logic [ymrc_pkg::ADDR_W-1:0]      flash_address,
  output logic [ymrc_pkg::HALF_W-1:0]      halfword,
  output logic [ymrc_pkg::BYTE_W-1:0]      tx_byte,
  output logic [1:0]                       process,
  output logic                             last
);
  import ymrc_pkg::*;

  bundle_t    held;
  logic       full;
  logic [1:0] idx;
  logic       is_last;
  logic       pop;
  result_t    cur;

  assign cur     = held.res[idx];
  assign is_last = (idx == held.count - 2'd1);
  assign pop     = full && !out_stall;
  assign ready   = !full || (pop && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (pop && !is_last) begin
      idx <= idx + 2'd1;
    end else if (ready) begin
      full <= push;
      idx  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      held <= push_bundle;
    end
  end

  assign out_valid     = full;
  assign kind          = cur.kind;
  assign flash_address = cur.flash_address;
  assign halfword      = cur.halfword;
  assign tx_byte       = cur.tx_byte;
  assign process       = held.process;
  assign last          = is_last;

endmodule : ymrc_out_queue
`default_nettype wire
